// File: design/segment_intersection_filter_top_assert.svh
// assertion macros for the segment intersection filter
// used by the checker bound to the top level; no other dependencies
`ifndef SEGMENT_INTERSECTION_FILTER_TOP_ASSERT_SVH
`define SEGMENT_INTERSECTION_FILTER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SIF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sif assertion failed");

// antecedent implies consequent in the next cycle
`define SIF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sif assertion failed");

`endif

// File: design/sif_pkg.sv
// shared types and constants for the segment intersection filter
// no dependencies; imported by sif_cross, the top level, the checker and the testbench
`timescale 1ns / 1ps
`default_nettype none

package sif_pkg;

  localparam int SIF_MAX_SEGMENTS = 64;
  localparam int SIF_COORD_BITS   = 12;

  localparam int LIMIT_W  = 7;
  localparam int STATUS_W = 2;
  localparam int HIT_W    = 6;
  localparam int SEGCNT_W = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_CLEARED  = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  // one crossing test result leaving the pipeline
  typedef struct packed {
    logic valid;
    logic hit;
  } cross_res_t;

endpackage

`default_nettype wire

// File: design/sif_mem.sv
// segment table storage: one write port, one read port, registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sif_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 48,
  parameter int AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: design/sif_cross.sv
// crossing test pipeline: differences, products, orientation compares
// depends on sif_pkg; fed by sif_mem read data
`timescale 1ns / 1ps
`default_nettype none

module sif_cross #(
  parameter int CB = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                flush_i,
  input  wire logic                issue_i,
  input  wire logic [4*CB-1:0]     cand_i,
  input  wire logic [4*CB-1:0]     entry_i,
  output sif_pkg::cross_res_t      res_o
);

  import sif_pkg::*;

  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;

  logic          v1_q, v2_q, v3_q;
  logic [CB-1:0] ax, ay, bx, by, cx, cy, dx, dy;

  logic signed [DW-1:0] cxa_q, cya_q, dxa_q, dya_q;
  logic signed [DW-1:0] cxb_q, cyb_q, dxb_q, dyb_q;
  logic signed [DW-1:0] bax_q, bay_q;

  logic signed [PW-1:0] pa1_q, pa2_q, pb1_q, pb2_q;
  logic signed [PW-1:0] pc1_q, pc2_q, pd1_q, pd2_q;

  logic oa, ob, oc, od;

  // unpack candidate (a, b) and stored segment (c, d)
  assign {ax, ay, bx, by} = cand_i;
  assign {cx, cy, dx, dy} = entry_i;

  // valid tags follow the memory latency and both arithmetic stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (flush_i) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage 2: coordinate differences
  always_ff @(posedge clk_i) begin
    cxa_q <= $signed({1'b0, cx}) - $signed({1'b0, ax});
    cya_q <= $signed({1'b0, cy}) - $signed({1'b0, ay});
    dxa_q <= $signed({1'b0, dx}) - $signed({1'b0, ax});
    dya_q <= $signed({1'b0, dy}) - $signed({1'b0, ay});
    cxb_q <= $signed({1'b0, cx}) - $signed({1'b0, bx});
    cyb_q <= $signed({1'b0, cy}) - $signed({1'b0, by});
    dxb_q <= $signed({1'b0, dx}) - $signed({1'b0, bx});
    dyb_q <= $signed({1'b0, dy}) - $signed({1'b0, by});
    bax_q <= $signed({1'b0, bx}) - $signed({1'b0, ax});
    bay_q <= $signed({1'b0, by}) - $signed({1'b0, ay});
  end

  // stage 3: cross products, one multiplier per term
  always_ff @(posedge clk_i) begin
    pa1_q <= dya_q * cxa_q;
    pa2_q <= cya_q * dxa_q;
    pb1_q <= dyb_q * cxb_q;
    pb2_q <= cyb_q * dxb_q;
    pc1_q <= cya_q * bax_q;
    pc2_q <= bay_q * cxa_q;
    pd1_q <= dya_q * bax_q;
    pd2_q <= bay_q * dxa_q;
  end

  // strict orientation compares and the crossing decision
  assign oa = pa1_q > pa2_q;
  assign ob = pb1_q > pb2_q;
  assign oc = pc1_q > pc2_q;
  assign od = pd1_q > pd2_q;

  assign res_o.valid = v3_q;
  assign res_o.hit   = (oa != ob) && (oc != od);

endmodule

`default_nettype wire

// File: design/segment_intersection_filter_top.sv
// Segment intersection filter. A test item (mode 0) is checked against the stored segments in
// index order, one table entry read per cycle from the single read port of the segment memory,
// through a three-stage crossing pipeline. A clear item, an item that finds the table full
// (count at or above min(segment_limit, MAX_SEGMENTS)) or an item that meets an empty table is
// settled in the idle state, with no scan. Otherwise the scan stops at the first entry crossed
// or, when nothing is crossed, once the last stored entry is tested; the read rate paces it.
// A result waits in an output register, and the next item is taken in the cycle it is
// transferred. There is no clearing pass: entries are read only below the stored count.
// depends on sif_pkg, sif_mem and sif_cross
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection_filter_top #(
  parameter int MAX_SEGMENTS = sif_pkg::SIF_MAX_SEGMENTS,
  parameter int COORD_BITS   = sif_pkg::SIF_COORD_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [sif_pkg::LIMIT_W-1:0]    cfg_data_i,
  // input item channel
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           mode_i,
  input  wire logic [COORD_BITS-1:0]          start_x_i,
  input  wire logic [COORD_BITS-1:0]          start_y_i,
  input  wire logic [COORD_BITS-1:0]          end_x_i,
  input  wire logic [COORD_BITS-1:0]          end_y_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [sif_pkg::STATUS_W-1:0]   status_o,
  output logic      [sif_pkg::HIT_W-1:0]      hit_index_o,
  output logic      [sif_pkg::SEGCNT_W-1:0]   segment_count_o
);

  import sif_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int ENT_W  = 4 * COORD_BITS;
  localparam int RW     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_SEGMENTS);
  localparam logic [CNT_W-1:0] OneCnt = CNT_W'(1);

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     issue_q, issue_d;
  logic [CNT_W-1:0]     ret_q, ret_d;
  logic [LIMIT_W-1:0]   limit_q;
  logic [ENT_W-1:0]     cand_q;
  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic [HIT_W-1:0]     hit_q, hit_d;
  logic [SEGCNT_W-1:0]  segcnt_q, segcnt_d;

  logic                 in_fire, cand_load, issue_en, flush, fin, full;
  logic                 wr_en;
  logic [ENT_W-1:0]     in_entry, wr_data, rd_data;
  logic [CNT_W-1:0]     ret_inc;
  logic [RW-1:0]        cnt_wide, ret_wide;
  cross_res_t           res;

  assign in_entry = {start_x_i, start_y_i, end_x_i, end_y_i};
  assign in_fire  = in_valid_i && in_ready_o;
  assign ret_inc  = ret_q + OneCnt;
  assign ret_wide = RW'(ret_q);

  // table full against the limit in effect
  assign full = (RW'(count_q) >= RW'(limit_q)) || (count_q >= MaxCnt);

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // candidate held for the whole scan
  always_ff @(posedge clk_i) begin
    if (cand_load) begin
      cand_q <= in_entry;
    end
  end

  // control state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      ret_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_ACCEPTED;
      hit_q       <= '0;
      segcnt_q    <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      hit_q       <= hit_d;
      segcnt_q    <= segcnt_d;
    end
  end

  // next state, memory writes and result production
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    issue_d     = issue_q;
    ret_d       = ret_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    hit_d       = hit_q;
    segcnt_d    = segcnt_q;
    in_ready_o  = 1'b0;
    cand_load   = 1'b0;
    issue_en    = 1'b0;
    flush       = 1'b0;
    fin         = 1'b0;
    wr_en       = 1'b0;
    wr_data     = cand_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        if (in_fire) begin
          if (mode_i) begin
            count_d  = '0;
            status_d = ST_CLEARED;
            hit_d    = '0;
            fin      = 1'b1;
          end else if (full) begin
            status_d = ST_FULL;
            hit_d    = '0;
            fin      = 1'b1;
          end else if (count_q == '0) begin
            wr_en    = 1'b1;
            wr_data  = in_entry;
            count_d  = OneCnt;
            status_d = ST_ACCEPTED;
            hit_d    = '0;
            fin      = 1'b1;
          end else begin
            cand_load = 1'b1;
            issue_d   = '0;
            ret_d     = '0;
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        issue_en = issue_q < count_q;
        if (issue_en) begin
          issue_d = issue_q + OneCnt;
        end
        if (res.valid) begin
          if (res.hit) begin
            // first crossing in index order; drop the later reads in flight
            flush    = 1'b1;
            status_d = ST_REJECTED;
            hit_d    = ret_wide[HIT_W-1:0];
            fin      = 1'b1;
            state_d  = S_IDLE;
          end else begin
            ret_d = ret_inc;
            if (ret_inc == count_q) begin
              wr_en    = 1'b1;
              count_d  = count_q + OneCnt;
              status_d = ST_ACCEPTED;
              hit_d    = '0;
              fin      = 1'b1;
              state_d  = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cnt_wide = RW'(count_d);
    if (fin) begin
      out_valid_d = 1'b1;
      segcnt_d    = cnt_wide[SEGCNT_W-1:0];
    end
  end

  // segment table; a write lands before the next scan reads it
  sif_mem #(
    .DEPTH (MAX_SEGMENTS),
    .WIDTH (ENT_W),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IDX_W-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (issue_en),
    .rd_addr_i (issue_q[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  // crossing test pipeline
  sif_cross #(
    .CB (COORD_BITS)
  ) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (flush),
    .issue_i (issue_en),
    .cand_i  (cand_q),
    .entry_i (rd_data),
    .res_o   (res)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign hit_index_o     = hit_q;
  assign segment_count_o = segcnt_q;

endmodule

`default_nettype wire

// File: design/sif_checker.sv
// port-level checker for the segment intersection filter, bound to the top level
// depends on sif_pkg and segment_intersection_filter_top_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "segment_intersection_filter_top_assert.svh"

module sif_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [sif_pkg::STATUS_W-1:0]   status_o,
  input wire logic [sif_pkg::HIT_W-1:0]      hit_index_o,
  input wire logic [sif_pkg::SEGCNT_W-1:0]   segment_count_o
);

  import sif_pkg::*;

  // a stalled result keeps its status
  `SIF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o))

  // a clear empties the table and reports a zero hit index
  `SIF_ASSERT_IMP(a_clear_zero, clk_i, rst_ni, out_valid_o && (status_o == ST_CLEARED), (hit_index_o == '0) && (segment_count_o == '0))

  // only a rejection carries a hit index
  `SIF_ASSERT_IMP(a_hit_only_reject, clk_i, rst_ni, out_valid_o && ((status_o == ST_ACCEPTED) || (status_o == ST_FULL)), hit_index_o == '0)

  // an accepted segment leaves the table non-empty
  `SIF_ASSERT_IMP(a_accept_count, clk_i, rst_ni, out_valid_o && (status_o == ST_ACCEPTED), segment_count_o != '0)

endmodule

bind segment_intersection_filter_top sif_checker u_sif_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .hit_index_o     (hit_index_o),
  .segment_count_o (segment_count_o)
);

`default_nettype wire

// File: test/tb_segment_intersection_filter_top.sv
// testbench for segment_intersection_filter_top: directed table, then random phases
// needs sif_pkg and the filter top level; a table model predicts untyped verdicts
`timescale 1ns / 1ps

module tb_segment_intersection_filter_top;
  import sif_pkg::*;

  typedef logic [SIF_COORD_BITS-1:0] coord_t;

  // one line segment, first endpoint then second
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } seg_t;

  typedef struct packed {
    status_e              status;
    logic [HIT_W-1:0]     hit;
    logic [SEGCNT_W-1:0]  count;
  } verdict_t;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic                 mode;
    coord_t               sx;
    coord_t               sy;
    coord_t               ex;
    coord_t               ey;
    logic [LIMIT_W-1:0]   limit;
    logic                 typed;
    verdict_t             want;
  } dir_row_t;

  localparam logic MODE_TEST  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int DRAIN_CYCLES    = 100;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 320;
  localparam int NUM_PHASES      = 6;
  localparam int PRESSURE_PHASE  = 5;
  localparam int MAX_PRINTS      = 100;

  localparam int PHASE_LIMIT [NUM_PHASES] = '{64, 127, 1, 17, 0, 63};
  localparam int PHASE_SEND  [NUM_PHASES] = '{0, 59, 0, 17, 0, 0};
  localparam int PHASE_RECV  [NUM_PHASES] = '{0, 0, 59, 17, 0, 0};

  localparam verdict_t NO_VERDICT = '{ST_ACCEPTED, 0, 0};

  // directed stimulus; typed verdicts only where they are obvious
  localparam int NUM_DIR = 20;
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{ROW_ITEM, MODE_CLEAR, 4095, 4095, 4095, 4095, 0, 1'b1, '{ST_CLEARED, 0, 0}},
    '{ROW_ITEM, MODE_TEST, 0, 0, 4095, 4095, 0, 1'b1, '{ST_ACCEPTED, 0, 1}},
    '{ROW_ITEM, MODE_TEST, 0, 4095, 4095, 0, 0, 1'b1, '{ST_REJECTED, 0, 1}},
    // zero length, collinear overlap, endpoint touching
    '{ROW_ITEM, MODE_TEST, 100, 100, 100, 100, 0, 1'b0, NO_VERDICT},
    '{ROW_ITEM, MODE_TEST, 10, 10, 20, 20, 0, 1'b0, NO_VERDICT},
    '{ROW_ITEM, MODE_TEST, 2048, 2048, 4095, 0, 0, 1'b0, NO_VERDICT},
    '{ROW_ITEM, MODE_TEST, 0, 4095, 4095, 4095, 0, 1'b0, NO_VERDICT},
    '{ROW_ITEM, MODE_TEST, 4095, 0, 0, 4095, 0, 1'b0, NO_VERDICT},
    // limit lowered below the stored count
    '{ROW_CFG, MODE_TEST, 0, 0, 0, 0, 0, 1'b0, NO_VERDICT},
    '{ROW_ITEM, MODE_TEST, 1, 2, 3, 4, 0, 1'b0, NO_VERDICT},
    '{ROW_CFG, MODE_TEST, 0, 0, 0, 0, 127, 1'b0, NO_VERDICT},
    '{ROW_ITEM, MODE_CLEAR, 0, 0, 0, 0, 0, 1'b1, '{ST_CLEARED, 0, 0}},
    // small limit fills up
    '{ROW_CFG, MODE_TEST, 0, 0, 0, 0, 2, 1'b0, NO_VERDICT},
    '{ROW_ITEM, MODE_TEST, 0, 0, 2, 0, 0, 1'b1, '{ST_ACCEPTED, 0, 1}},
    '{ROW_ITEM, MODE_TEST, 0, 10, 2, 10, 0, 1'b1, '{ST_ACCEPTED, 0, 2}},
    '{ROW_ITEM, MODE_TEST, 5, 5, 6, 6, 0, 1'b1, '{ST_FULL, 0, 2}},
    '{ROW_CFG, MODE_TEST, 0, 0, 0, 0, 64, 1'b0, NO_VERDICT},
    // crosses the second entry only
    '{ROW_ITEM, MODE_TEST, 1, 5, 1, 20, 0, 1'b1, '{ST_REJECTED, 1, 2}},
    '{ROW_ITEM, MODE_TEST, 1, 4095, 1, 11, 0, 1'b0, NO_VERDICT},
    '{ROW_ITEM, MODE_CLEAR, 1, 2, 3, 4, 0, 1'b1, '{ST_CLEARED, 0, 0}}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [LIMIT_W-1:0]     cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic                   mode_i = MODE_TEST;
  coord_t                 start_x_i = '0;
  coord_t                 start_y_i = '0;
  coord_t                 end_x_i = '0;
  coord_t                 end_y_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [STATUS_W-1:0]    status_o;
  logic [HIT_W-1:0]       hit_index_o;
  logic [SEGCNT_W-1:0]    segment_count_o;

  // verdict typed in by the directed table, travels with the payload
  logic                   cur_typed = 1'b0;
  verdict_t               cur_want = NO_VERDICT;

  // predictor state
  seg_t                   seg_table_model [SIF_MAX_SEGMENTS];
  int                     seg_count_model = 0;
  logic [LIMIT_W-1:0]     limit_model = LIMIT_RESET;
  verdict_t               pending_verdicts [$];

  int                     mismatch_count = 0;
  int                     cycle_count = 0;
  int                     send_idle_pct = 0;
  int                     recv_stall_pct = 0;
  logic                   hold_req = 1'b0;

  segment_intersection_filter_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .hit_index_o     (hit_index_o),
    .segment_count_o (segment_count_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // strict orientation of r relative to p->q
  function automatic logic is_ccw(coord_t px, coord_t py, coord_t qx, coord_t qy,
                                  coord_t rx, coord_t ry);
    logic signed [SIF_COORD_BITS:0]     d_ry, d_qx, d_qy, d_rx;
    logic signed [2*SIF_COORD_BITS+1:0] lhs, rhs;
    d_ry = $signed({1'b0, ry}) - $signed({1'b0, py});
    d_qx = $signed({1'b0, qx}) - $signed({1'b0, px});
    d_qy = $signed({1'b0, qy}) - $signed({1'b0, py});
    d_rx = $signed({1'b0, rx}) - $signed({1'b0, px});
    lhs = d_ry * d_qx;
    rhs = d_qy * d_rx;
    return lhs > rhs;
  endfunction

  function automatic logic segments_cross(seg_t s, seg_t t);
    logic a, b, c, d;
    a = is_ccw(s.ax, s.ay, t.ax, t.ay, t.bx, t.by);
    b = is_ccw(s.bx, s.by, t.ax, t.ay, t.bx, t.by);
    c = is_ccw(s.ax, s.ay, s.bx, s.by, t.ax, t.ay);
    d = is_ccw(s.ax, s.ay, s.bx, s.by, t.bx, t.by);
    return (a != b) && (c != d);
  endfunction

  // verdict for one item, updating the table model
  function automatic verdict_t judge_candidate(logic mode, seg_t cand);
    verdict_t r;
    int       lim;
    logic     found;
    lim = (int'(limit_model) > SIF_MAX_SEGMENTS) ? SIF_MAX_SEGMENTS : int'(limit_model);
    r = NO_VERDICT;
    found = 1'b0;
    if (mode == MODE_CLEAR) begin
      seg_count_model = 0;
      r.status = ST_CLEARED;
    end else if (seg_count_model >= lim) begin
      r.status = ST_FULL;
    end else begin
      for (int i = 0; i < seg_count_model; i++) begin
        if (!found && segments_cross(cand, seg_table_model[i])) begin
          found = 1'b1;
          r.status = ST_REJECTED;
          r.hit = HIT_W'(i);
        end
      end
      if (!found) begin
        seg_table_model[seg_count_model] = cand;
        seg_count_model++;
      end
    end
    r.count = SEGCNT_W'(seg_count_model);
    return r;
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v < 0) return '0;
    if (v > (1 << SIF_COORD_BITS) - 1) return '1;
    return coord_t'(v);
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
  endtask

  // offer one item after a random gap, return at its transfer
  task automatic send_item(input logic mode, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey,
                           input logic typed, input verdict_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    start_x_i <= sx;
    start_y_i <= sy;
    end_x_i <= ex;
    end_y_i <= ey;
    cur_typed <= typed;
    cur_want <= want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // stop offering and wait for every pending verdict
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off when asked
  always begin
    @(posedge clk_i);
    if (hold_req) begin
      out_ready_i <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_req = 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on input transfer, check on result transfer
  always @(posedge clk_i) begin
    verdict_t v;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) limit_model = cfg_data_i;
      if (in_valid_i && in_ready_o) begin
        v = judge_candidate(mode_i, '{start_x_i, start_y_i, end_x_i, end_y_i});
        pending_verdicts.push_back(cur_typed ? cur_want : v);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_verdicts.size() == 0) begin
          flag_mismatch("result with nothing pending, status", status_o, -1);
        end else begin
          v = pending_verdicts.pop_front();
          if (status_o != v.status) flag_mismatch("status", status_o, v.status);
          if (hit_index_o != v.hit) flag_mismatch("hit_index", hit_index_o, v.hit);
          if (segment_count_o != v.count)
            flag_mismatch("segment_count", segment_count_o, v.count);
        end
      end
    end
  end

  // stimulus
  initial begin
    logic   m;
    coord_t sx, sy, ex, ey;
    int     pick, cnt, j;
    seg_t   ref_seg;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    send_idle_pct = 17;
    recv_stall_pct = 17;
    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].kind == ROW_CFG) begin
        wait_idle();
        write_limit(DIR_ROWS[r].limit);
      end else begin
        send_item(DIR_ROWS[r].mode, DIR_ROWS[r].sx, DIR_ROWS[r].sy, DIR_ROWS[r].ex,
                  DIR_ROWS[r].ey, DIR_ROWS[r].typed, DIR_ROWS[r].want);
      end
    end

    // random phases with different limits and idling
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      write_limit(LIMIT_W'(PHASE_LIMIT[ph]));
      send_idle_pct = PHASE_SEND[ph];
      recv_stall_pct = PHASE_RECV[ph];
      if (ph == PRESSURE_PHASE) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        m = MODE_TEST;
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        ex = coord_t'($urandom);
        ey = coord_t'($urandom);
        pick = $urandom_range(99);
        if ($urandom_range(99) < 2) begin
          m = MODE_CLEAR;
        end else if (pick < 45) begin
          // short segment, likely to fit among the stored ones
          ex = clamp_coord(int'(sx) + int'($urandom_range(600)) - 300);
          ey = clamp_coord(int'(sy) + int'($urandom_range(600)) - 300);
        end else if (pick < 85 && pick >= 75) begin
          // start on an endpoint of a stored segment
          cnt = seg_count_model;
          if (cnt > 0) begin
            j = $urandom_range(cnt - 1);
            ref_seg = seg_table_model[j];
            if ($urandom_range(1) == 1) begin
              sx = ref_seg.ax;
              sy = ref_seg.ay;
            end else begin
              sx = ref_seg.bx;
              sy = ref_seg.by;
            end
            ex = clamp_coord(int'(sx) + int'($urandom_range(600)) - 300);
            ey = clamp_coord(int'(sy) + int'($urandom_range(600)) - 300);
          end
        end else if (pick < 92 && pick >= 85) begin
          // coarse grid, collinear and shared points are common
          sx = coord_t'($urandom_range(15) * 273);
          sy = coord_t'($urandom_range(15) * 273);
          ex = coord_t'($urandom_range(15) * 273);
          ey = coord_t'($urandom_range(15) * 273);
        end else if (pick >= 92) begin
          ex = sx;
          ey = sy;
        end
        send_item(m, sx, sy, ex, ey, 1'b0, NO_VERDICT);
      end
    end

    // drain
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_verdicts.size() != 0)
      flag_mismatch("verdicts left pending", pending_verdicts.size(), 0);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: segment_intersection_filter_top.f
+incdir+design
design/sif_pkg.sv
design/sif_mem.sv
design/sif_cross.sv
design/segment_intersection_filter_top.sv
design/sif_checker.sv
test/tb_segment_intersection_filter_top.sv
